// ----- rtl/core/wst_pkg.sv -----
// ----------------------------------------------------------------------------
// wst_pkg
// Shared types and constants for the work slot table: operation codes,
// state codes, the packed slot word and the controller/datapath interface.
// ----------------------------------------------------------------------------
package wst_pkg;

  // Default number of slots in the table.
  localparam int SLOTS_DEF = 8;

  // Field widths of one request and one response.
  localparam int FUNC_W      = 3;
  localparam int IDX_W       = 3;
  localparam int CODE_W      = 4;
  localparam int SEQ_W       = 8;
  localparam int STAMP_W     = 32;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 8;

  // Slot state codes with a fixed meaning.
  localparam logic [CODE_W-1:0] ST_FREE    = 4'd0;
  localparam logic [CODE_W-1:0] ST_PENDING = 4'd1;

  // Operation selector codes.
  typedef enum logic [FUNC_W-1:0] {
    FN_ALLOC      = 3'd0,
    FN_SET_STATE  = 3'd1,
    FN_GET_OLDEST = 3'd2,
    FN_FREE       = 3'd3,
    FN_FIND_SEQ   = 3'd4,
    FN_SET_SEQ    = 3'd5
  } func_t;

  // One entry of the slot memory.
  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic [STAMP_W-1:0] stamp;
    logic [SEQ_W-1:0]   seq;
  } slot_word_t;

  // Controller states.
  typedef enum logic [2:0] {
    CS_IDLE,
    CS_SCAN,
    CS_LAST,
    CS_READ,
    CS_WRITE,
    CS_DONE
  } ctl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;
    logic rd_scan;
    logic rd_tgt;
    logic wr;
    logic ld_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [FUNC_W-1:0] in_func;
    logic              in_idx_ok;
    logic              scan_last;
    logic              out_free;
  } sts_t;

endpackage

// ----- rtl/core/wst_ctrl.sv -----
// ----------------------------------------------------------------------------
// wst_ctrl
// Sequencer of the work slot table: walks each request through scan,
// target read, write-back and response phases.
// ----------------------------------------------------------------------------
module wst_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  wst_pkg::sts_t sts,
  output wst_pkg::cmd_t cmd
);

  wst_pkg::ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wst_pkg::CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wst_pkg::CS_IDLE: begin
        if (in_tvalid) begin
          case (sts.in_func)
            wst_pkg::FN_ALLOC, wst_pkg::FN_GET_OLDEST, wst_pkg::FN_FIND_SEQ: begin
              state_nxt = wst_pkg::CS_SCAN;
            end
            wst_pkg::FN_SET_STATE, wst_pkg::FN_SET_SEQ: begin
              state_nxt = sts.in_idx_ok ? wst_pkg::CS_READ : wst_pkg::CS_DONE;
            end
            wst_pkg::FN_FREE: begin
              state_nxt = sts.in_idx_ok ? wst_pkg::CS_WRITE : wst_pkg::CS_DONE;
            end
            default: begin
              state_nxt = wst_pkg::CS_DONE;
            end
          endcase
        end
      end
      wst_pkg::CS_SCAN: begin
        if (sts.scan_last) begin
          state_nxt = wst_pkg::CS_LAST;
        end
      end
      wst_pkg::CS_LAST:  state_nxt = wst_pkg::CS_WRITE;
      wst_pkg::CS_READ:  state_nxt = wst_pkg::CS_WRITE;
      wst_pkg::CS_WRITE: state_nxt = wst_pkg::CS_DONE;
      wst_pkg::CS_DONE: begin
        if (sts.out_free) begin
          state_nxt = wst_pkg::CS_IDLE;
        end
      end
      default: state_nxt = wst_pkg::CS_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      wst_pkg::CS_IDLE: begin
        in_tready    = 1'b1;
        cmd.load_req = in_tvalid;
      end
      wst_pkg::CS_SCAN:  cmd.rd_scan = 1'b1;
      wst_pkg::CS_READ:  cmd.rd_tgt  = 1'b1;
      wst_pkg::CS_WRITE: cmd.wr      = 1'b1;
      wst_pkg::CS_DONE:  cmd.ld_out  = sts.out_free;
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/core/wst_dp.sv -----
// ----------------------------------------------------------------------------
// wst_dp
// Datapath of the work slot table: request registers, slot memory with
// per-slot valid bits, the scan evaluator and the response register.
// ----------------------------------------------------------------------------
module wst_dp #(
  parameter int SLOTS = wst_pkg::SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  wst_pkg::cmd_t               cmd,
  output wst_pkg::sts_t               sts,
  input  logic [wst_pkg::FUNC_W-1:0]  in_func,
  input  logic [wst_pkg::IDX_W-1:0]   in_slot_index,
  input  logic [wst_pkg::CODE_W-1:0]  in_state_code,
  input  logic [wst_pkg::SEQ_W-1:0]   in_seq_value,
  input  logic                        in_skip_valid,
  input  logic [wst_pkg::IDX_W-1:0]   in_skip_index,
  input  logic [wst_pkg::STAMP_W-1:0] in_now,
  input  logic                        out_tready,
  output logic                        out_tvalid,
  output logic                        out_found,
  output logic [wst_pkg::IDX_W-1:0]   out_result_index
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Request registers.
  logic [wst_pkg::FUNC_W-1:0]  req_func_r;
  logic [wst_pkg::IDX_W-1:0]   req_idx_r;
  logic [wst_pkg::CODE_W-1:0]  req_code_r;
  logic [wst_pkg::SEQ_W-1:0]   req_seq_r;
  logic                        req_skipv_r;
  logic [wst_pkg::IDX_W-1:0]   req_skip_r;
  logic [wst_pkg::STAMP_W-1:0] req_now_r;

  // Slot memory and valid bits.
  wst_pkg::slot_word_t mem_r [SLOTS];
  logic [SLOTS-1:0]    vld_r;

  // Read port pipeline.
  wst_pkg::slot_word_t rd_word_r;
  logic [IW-1:0]       rd_idx_r;
  logic                rd_vld_r;
  logic                rd_pend_r;

  // Scan state.
  logic [IW-1:0]       cnt_r;
  logic                hit_r;
  logic [IW-1:0]       best_idx_r;
  wst_pkg::slot_word_t best_word_r;

  // Response register.
  logic                      out_valid_r;
  logic                      out_found_r;
  logic [wst_pkg::IDX_W-1:0] out_idx_r;

  logic                is_alloc, is_old, is_find;
  logic [IW-1:0]       idx_w, raddr;
  logic                re;
  wst_pkg::slot_word_t word_w, wword;
  logic                we, set_vld, clr_vld;
  logic [IW-1:0]       waddr;
  logic                skip_hit, take;

  assign is_alloc = (req_func_r == wst_pkg::FN_ALLOC);
  assign is_old   = (req_func_r == wst_pkg::FN_GET_OLDEST);
  assign is_find  = (req_func_r == wst_pkg::FN_FIND_SEQ);

  assign idx_w = IW'(req_idx_r);
  assign re    = cmd.rd_scan | cmd.rd_tgt;
  assign raddr = cmd.rd_scan ? cnt_r : idx_w;

  // An entry that was never written, or was freed, reads as all zero.
  assign word_w   = rd_vld_r ? rd_word_r : '0;
  assign skip_hit = req_skipv_r && (32'(rd_idx_r) == 32'(req_skip_r));

  always_comb begin
    take = 1'b0;
    if (is_alloc) begin
      take = (word_w.code == wst_pkg::ST_FREE) && !hit_r;
    end else if (is_old) begin
      take = (word_w.code == req_code_r) && (!hit_r || (word_w.stamp < best_word_r.stamp));
    end else if (is_find) begin
      take = (word_w.code != wst_pkg::ST_FREE) && (word_w.seq == req_seq_r) &&
             !skip_hit && !hit_r;
    end
  end

  // Write-back of the located or addressed slot.
  always_comb begin
    we      = 1'b0;
    set_vld = 1'b0;
    clr_vld = 1'b0;
    waddr   = idx_w;
    wword   = word_w;
    if (cmd.wr) begin
      case (req_func_r)
        wst_pkg::FN_ALLOC: begin
          we      = hit_r;
          set_vld = hit_r;
          waddr   = best_idx_r;
          wword   = '{code: wst_pkg::ST_PENDING, stamp: best_word_r.stamp,
                      seq: best_word_r.seq};
        end
        wst_pkg::FN_GET_OLDEST: begin
          we      = hit_r;
          set_vld = hit_r;
          waddr   = best_idx_r;
          wword   = '{code: best_word_r.code, stamp: req_now_r, seq: best_word_r.seq};
        end
        wst_pkg::FN_SET_STATE: begin
          we      = 1'b1;
          set_vld = 1'b1;
          wword   = '{code: req_code_r, stamp: req_now_r, seq: word_w.seq};
        end
        wst_pkg::FN_SET_SEQ: begin
          we      = 1'b1;
          set_vld = 1'b1;
          wword   = '{code: word_w.code, stamp: word_w.stamp, seq: req_seq_r};
        end
        wst_pkg::FN_FREE: begin
          clr_vld = 1'b1;
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_func_r  <= in_func;
      req_idx_r   <= in_slot_index;
      req_code_r  <= in_state_code;
      req_seq_r   <= in_seq_value;
      req_skipv_r <= in_skip_valid;
      req_skip_r  <= in_skip_index;
      req_now_r   <= in_now;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wword;
    end
    if (re) begin
      rd_word_r <= mem_r[raddr];
      rd_idx_r  <= raddr;
      rd_vld_r  <= vld_r[raddr];
    end
    if (rd_pend_r && take) begin
      best_idx_r  <= rd_idx_r;
      best_word_r <= word_w;
    end
    if (cmd.ld_out) begin
      out_found_r <= hit_r;
      out_idx_r   <= hit_r ? wst_pkg::IDX_W'(best_idx_r) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      rd_pend_r   <= 1'b0;
      cnt_r       <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_pend_r <= re;
      if (set_vld) begin
        vld_r[waddr] <= 1'b1;
      end else if (clr_vld) begin
        vld_r[waddr] <= 1'b0;
      end
      if (cmd.load_req) begin
        cnt_r <= '0;
        hit_r <= 1'b0;
      end else begin
        if (cmd.rd_scan) begin
          cnt_r <= cnt_r + 1'b1;
        end
        if (rd_pend_r && take) begin
          hit_r <= 1'b1;
        end
      end
      if (cmd.ld_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.in_func   = in_func;
  assign sts.in_idx_ok = (32'(in_slot_index) < 32'(SLOTS));
  assign sts.scan_last = (cnt_r == IW'(SLOTS - 1));
  assign sts.out_free  = !out_valid_r || out_tready;

  assign out_tvalid       = out_valid_r;
  assign out_found        = out_found_r;
  assign out_result_index = out_idx_r;

endmodule

// ----- rtl/core/work_slot_table.sv -----
// ----------------------------------------------------------------------------
// work_slot_table
// Table of work slots (state code, timestamp, sequence byte) serving six
// operations through a request stream and a response stream.
// ----------------------------------------------------------------------------
// Each request on the in_ stream produces exactly one response on the out_
// stream, and requests are handled one at a time. The slot words live in a
// single-port memory with one valid bit per slot, so a slot that was never
// written or was freed reads as all zero without any clearing pass. The one
// memory read port sets the timing: allocate, get-oldest and find-sequence
// read one slot per cycle over every slot, then evaluate the last slot,
// write back and load the response before the next acceptance; set-state
// and set-sequence read, modify and write the addressed slot, free clears
// the slot's valid bit, and an unused selector or an out-of-range slot
// index goes straight to the response. A finished response waits in an output
// register, so the sequencer only stalls when that register is still full.
// Get-oldest compares timestamps as plain unsigned 32-bit values, and on a
// tie the lowest slot index wins. result_index carries the low three bits
// of the located slot and is zero whenever found is zero.
// ----------------------------------------------------------------------------
module work_slot_table #(
  parameter int SLOTS = wst_pkg::SLOTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata, from bit 0 up: func[2:0], slot_index[5:3], state_code[9:6],
  // seq_value[17:10], skip_valid[18], skip_index[21:19], now[53:22], zeros.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [wst_pkg::IN_TDATA_W-1:0]     in_tdata,
  // out_tdata, from bit 0 up: found[0], result_index[3:1], zeros.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [wst_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  wst_pkg::cmd_t cmd;
  wst_pkg::sts_t sts;

  logic                      out_found;
  logic [wst_pkg::IDX_W-1:0] out_result_index;

  // The sequencer decides what happens in each cycle; the datapath holds the
  // request, the slot memory and the response.
  wst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  wst_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_func          (in_tdata[2:0]),
    .in_slot_index    (in_tdata[5:3]),
    .in_state_code    (in_tdata[9:6]),
    .in_seq_value     (in_tdata[17:10]),
    .in_skip_valid    (in_tdata[18]),
    .in_skip_index    (in_tdata[21:19]),
    .in_now           (in_tdata[53:22]),
    .out_tready       (out_tready),
    .out_tvalid       (out_tvalid),
    .out_found        (out_found),
    .out_result_index (out_result_index)
  );

  // The top two bits of in_tdata are padding and are not used.
  assign out_tdata = {4'b0000, out_result_index, out_found};

endmodule

// ----- rtl/core/wst_checker.sv -----
// ----------------------------------------------------------------------------
// wst_checker
// Port-level checks of the work slot table, bound to its top level.
// ----------------------------------------------------------------------------
module wst_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [wst_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [wst_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // A stalled response stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("response withdrawn while stalled");

  // A stalled response keeps its contents.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("response changed while stalled");

  // Requests are served one at a time: the block does not accept a request
  // in the cycle after it accepted one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted on consecutive cycles");

  // A miss reports index zero.
  a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[3:1] == 3'd0)
    else $error("non-zero index on a miss");

  // Padding bits of the response stay zero.
  a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:4] == 4'd0)
    else $error("response padding not zero");

endmodule

bind work_slot_table wst_checker u_wst_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
